@@ src/imucf_pkg.sv @@
// Shared types, constants and helper functions for the IMU complementary
// orientation filter. Used by imucf_cordic and imu_complementary_orientation_top.
`default_nettype none

package imucf_pkg;

   localparam int unsigned ANG_W        = 24;   // angle state, 1/256 degree
   localparam int unsigned CORD_W       = 28;   // cordic vector width
   localparam int unsigned Z_W          = 26;   // cordic angle, 1/65536 degree
   localparam int unsigned ANGR_W       = 18;   // cordic result, 1/256 degree
   localparam int unsigned CORDIC_STEPS = 17;
   localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);

   localparam logic [16:0] GYRO_WEIGHT_RESET = 17'd64225;
   localparam logic [16:0] WEIGHT_ONE        = 17'd65536;
   localparam logic [9:0]  MAX_STEP_RESET    = 10'd100;

   // floor(n / 125) = (n * RECIP_125) >> RECIP_SHIFT for n below 2^27
   localparam logic [27:0] RECIP_125   = 28'd137438954;
   localparam int unsigned RECIP_SHIFT = 34;

   localparam logic signed [25:0] HALF_TURN = 26'sd46080;
   localparam logic signed [25:0] FULL_TURN = 26'sd92160;
   localparam logic signed [Z_W-1:0] QUARTER_Z = 26'sd5898240;

   localparam logic signed [ANG_W-1:0] ANG_MAX = 24'sh7FFFFF;
   localparam logic signed [ANG_W-1:0] ANG_MIN = 24'sh800000;

   typedef enum logic [0:0] {
      CSR_GYRO_WEIGHT = 1'b0,
      CSR_MAX_STEP    = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_SUM,
      ST_SQRT,
      ST_ROLL_WAIT,
      ST_RATE_MUL,
      ST_RATE_RECIP,
      ST_RATE_INC,
      ST_PITCH_WAIT,
      ST_BLEND_W,
      ST_BLEND_A,
      ST_BLEND_FIN,
      ST_YAW,
      ST_DONE
   } state_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         5'd0:    r = 26'sd2949120;
         5'd1:    r = 26'sd1740967;
         5'd2:    r = 26'sd919879;
         5'd3:    r = 26'sd466945;
         5'd4:    r = 26'sd234379;
         5'd5:    r = 26'sd117304;
         5'd6:    r = 26'sd58666;
         5'd7:    r = 26'sd29335;
         5'd8:    r = 26'sd14668;
         5'd9:    r = 26'sd7334;
         5'd10:   r = 26'sd3667;
         5'd11:   r = 26'sd1833;
         5'd12:   r = 26'sd917;
         5'd13:   r = 26'sd458;
         5'd14:   r = 26'sd229;
         5'd15:   r = 26'sd115;
         5'd16:   r = 26'sd57;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat24(input logic signed [27:0] v);
      logic signed [ANG_W-1:0] r;
      if (v > 28'(ANG_MAX)) begin
         r = ANG_MAX;
      end else if (v < 28'(ANG_MIN)) begin
         r = ANG_MIN;
      end else begin
         r = v[ANG_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/imucf_cordic.sv @@
// Iterative vectoring cordic: atan2(y, x) in 1/256 degree, one rotation a cycle.
// Depends on imucf_pkg for widths and the arctangent table.
`default_nettype none

module imucf_cordic (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire logic signed [imucf_pkg::CORD_W-1:0] x_in,
   input  wire logic signed [imucf_pkg::CORD_W-1:0] y_in,
   output logic                                 done,
   output logic signed [imucf_pkg::ANGR_W-1:0]  angle
);
   import imucf_pkg::*;

   logic signed [CORD_W-1:0] x_ff, y_ff;
   logic signed [Z_W-1:0]    z_ff;
   logic [STEP_W-1:0]        i_ff;
   logic                     run_ff, fin_ff, done_ff;
   logic signed [ANGR_W-1:0] angle_ff;

   logic signed [CORD_W-1:0] x_sh, y_sh;
   logic [Z_W-1:0]           z_abs, z_q;
   logic signed [ANGR_W-1:0] z_round;

   always_comb begin
      x_sh    = x_ff >>> i_ff;
      y_sh    = y_ff >>> i_ff;
      z_abs   = z_ff[Z_W-1] ? Z_W'(-z_ff) : Z_W'(z_ff);
      z_q     = (z_abs + Z_W'(128)) >> 8;
      z_round = z_ff[Z_W-1] ? -$signed(z_q[ANGR_W-1:0]) : $signed(z_q[ANGR_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         fin_ff <= 1'b0;
         i_ff   <= '0;
         if (x_in == '0 && y_in == '0) begin
            angle_ff <= '0;
            done_ff  <= 1'b1;
            run_ff   <= 1'b0;
         end else begin
            done_ff <= 1'b0;
            run_ff  <= 1'b1;
            // pre-rotate left half plane by a quarter turn
            if (x_in < 0) begin
               if (y_in >= 0) begin
                  x_ff <= y_in;
                  y_ff <= -x_in;
                  z_ff <= QUARTER_Z;
               end else begin
                  x_ff <= -y_in;
                  y_ff <= x_in;
                  z_ff <= -QUARTER_Z;
               end
            end else begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= '0;
            end
         end
      end else if (run_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + atan_entry(i_ff);
         end else begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - atan_entry(i_ff);
         end
         i_ff <= i_ff + 1'b1;
         if (i_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            run_ff <= 1'b0;
            fin_ff <= 1'b1;
         end
      end else if (fin_ff) begin
         angle_ff <= z_round;
         done_ff  <= 1'b1;
         fin_ff   <= 1'b0;
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

`default_nettype wire

@@ src/imu_complementary_orientation_top.sv @@
// IMU complementary filter, roll / pitch / yaw at 1/256 degree.
// Each sample passes through the 24-step bit-serial square root, the pitch cordic and the
// shared 29x29 multiplier.
// A new sample is taken only when the last one is through; req_stall is high while busy.
// A finished response waits in its own register; the next sample may start once it is free.
// Synchronous reset clears the angles, last timestamp, state and rsp_valid; CSRs get defaults.
`default_nettype none

module imu_complementary_orientation_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_we,
   input  wire logic [0:0]        csr_index,
   input  wire logic [16:0]       csr_wdata,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   input  wire logic signed [15:0] req_rate_x,
   input  wire logic signed [15:0] req_rate_y,
   input  wire logic signed [15:0] req_rate_z,
   input  wire logic [31:0]       req_now_ms,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic signed [23:0]     rsp_roll_deg,
   output logic signed [23:0]     rsp_pitch_deg,
   output logic signed [23:0]     rsp_yaw_deg
);
   import imucf_pkg::*;

   state_type state_ff, state_in;

   logic [16:0] gyro_weight_ff;
   logic [9:0]  max_step_ff;
   logic signed [ANG_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic [31:0] last_stamp_ff;

   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] rate_ff [0:2];
   logic [9:0]  dt_ff;
   logic [16:0] w_ff;
   logic [1:0]  idx_ff;
   logic        sel_ff;
   logic        nsign_ff;
   logic signed [57:0] prod_ff;
   logic signed [43:0] sum_ff;
   logic signed [21:0] inc_ff [0:2];
   logic signed [ANGR_W-1:0] acc_roll_ff, acc_pitch_ff;
   logic [47:0] v_ff, r_ff, bit_ff;
   logic [4:0]  cnt_ff;

   logic        rsp_valid_ff;
   logic signed [23:0] out_roll_ff, out_pitch_ff, out_yaw_ff;

   logic signed [28:0] mul_a, mul_b;
   logic signed [57:0] mul_p;
   logic        cordic_start, cordic_done;
   logic signed [CORD_W-1:0] cordic_x, cordic_y;
   logic signed [ANGR_W-1:0] cordic_angle;

   logic        req_beat, out_load;
   logic [31:0] delta;
   logic [57:0] n_abs;
   logic [26:0] n_plus;
   logic [21:0] q_mag;
   logic signed [24:0] prev_sum;
   logic signed [ANGR_W-1:0] acc_sel;
   logic signed [43:0] b_sum;
   logic [43:0] b_abs, b_q;
   logic signed [27:0] b_res;
   logic [47:0] sq_trial;
   logic [31:0] sq_in;
   logic signed [25:0] y_sum, y_wrap1, y_wrap2;

   imucf_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (cordic_x),
      .y_in  (cordic_y),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   assign mul_p    = mul_a * mul_b;
   assign req_beat = req_valid && !req_stall;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // datapath helpers
   always_comb begin
      delta    = req_now_ms - last_stamp_ff;
      n_abs    = prod_ff[57] ? 58'(-prod_ff) : 58'(prod_ff);
      n_plus   = n_abs[26:0] + 27'd62;
      q_mag    = prod_ff[RECIP_SHIFT+21:RECIP_SHIFT];
      prev_sum = sel_ff ? (25'(pitch_ff) + 25'(inc_ff[1])) : (25'(roll_ff) + 25'(inc_ff[0]));
      acc_sel  = sel_ff ? acc_pitch_ff : acc_roll_ff;
      b_sum    = sum_ff + prod_ff[43:0];
      b_abs    = b_sum[43] ? 44'(-b_sum) : 44'(b_sum);
      b_q      = (b_abs + 44'd32768) >> 16;
      b_res    = b_sum[43] ? -$signed(b_q[27:0]) : $signed(b_q[27:0]);
      sq_trial = r_ff + bit_ff;
      sq_in    = sum_ff[31:0] + prod_ff[31:0];
      y_sum    = 26'(yaw_ff) + 26'(inc_ff[2]);
      y_wrap1  = (y_sum > HALF_TURN) ? y_sum - FULL_TURN : y_sum;
      y_wrap2  = (y_wrap1 < -HALF_TURN) ? y_wrap1 + FULL_TURN : y_wrap1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_beat) state_in = ST_SQ_Y;
         ST_SQ_Y:       state_in = ST_SQ_Z;
         ST_SQ_Z:       state_in = ST_SQ_SUM;
         ST_SQ_SUM:     state_in = ST_SQRT;
         ST_SQRT:       if (cnt_ff == 5'd23) state_in = ST_ROLL_WAIT;
         ST_ROLL_WAIT:  if (cordic_done) state_in = ST_RATE_MUL;
         ST_RATE_MUL:   state_in = ST_RATE_RECIP;
         ST_RATE_RECIP: state_in = ST_RATE_INC;
         ST_RATE_INC:   state_in = (idx_ff == 2'd2) ? ST_PITCH_WAIT : ST_RATE_MUL;
         ST_PITCH_WAIT: if (cordic_done) state_in = ST_BLEND_W;
         ST_BLEND_W:    state_in = ST_BLEND_A;
         ST_BLEND_A:    state_in = ST_BLEND_FIN;
         ST_BLEND_FIN:  state_in = sel_ff ? ST_YAW : ST_BLEND_W;
         ST_YAW:        state_in = ST_DONE;
         ST_DONE:       if (out_load) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: multiplier operands and cordic launch
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      mul_a        = '0;
      mul_b        = '0;
      cordic_start = 1'b0;
      cordic_x     = '0;
      cordic_y     = '0;
      case (state_ff)
         ST_SQ_Y: begin
            mul_a        = 29'(ay_ff);
            mul_b        = 29'(ay_ff);
            cordic_start = 1'b1;
            cordic_x     = 28'($signed({az_ff, 8'd0}));
            cordic_y     = 28'($signed({ay_ff, 8'd0}));
         end
         ST_SQ_Z: begin
            mul_a = 29'(az_ff);
            mul_b = 29'(az_ff);
         end
         ST_ROLL_WAIT: begin
            if (cordic_done) begin
               cordic_start = 1'b1;
               cordic_x     = $signed({4'd0, r_ff[23:0]});
               cordic_y     = -28'($signed({ax_ff, 8'd0}));
            end
         end
         ST_RATE_MUL: begin
            mul_a = 29'(rate_ff[idx_ff]);
            mul_b = $signed({18'd0, dt_ff, 1'b0});
         end
         ST_RATE_RECIP: begin
            mul_a = $signed({2'd0, n_plus});
            mul_b = $signed({1'b0, RECIP_125});
         end
         ST_BLEND_W: begin
            mul_a = $signed({12'd0, w_ff});
            mul_b = 29'(prev_sum);
         end
         ST_BLEND_A: begin
            mul_a = $signed({12'd0, 17'(WEIGHT_ONE - w_ff)});
            mul_b = 29'(acc_sel);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gyro_weight_ff <= GYRO_WEIGHT_RESET;
         max_step_ff    <= MAX_STEP_RESET;
         roll_ff        <= '0;
         pitch_ff       <= '0;
         yaw_ff         <= '0;
         last_stamp_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GYRO_WEIGHT: gyro_weight_ff <= csr_wdata;
               CSR_MAX_STEP:    max_step_ff    <= csr_wdata[9:0];
               default: begin
               end
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  last_stamp_ff <= req_now_ms;
               end
            end
            ST_BLEND_FIN: begin
               if (sel_ff) begin
                  pitch_ff <= sat24(b_res);
               end else begin
                  roll_ff <= sat24(b_res);
               end
            end
            ST_YAW:  yaw_ff <= sat24(28'(y_wrap2));
            default: begin
            end
         endcase
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (out_load) begin
         out_roll_ff  <= roll_ff;
         out_pitch_ff <= pitch_ff;
         out_yaw_ff   <= yaw_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            ax_ff      <= req_accel_x;
            ay_ff      <= req_accel_y;
            az_ff      <= req_accel_z;
            rate_ff[0] <= req_rate_x;
            rate_ff[1] <= req_rate_y;
            rate_ff[2] <= req_rate_z;
            dt_ff      <= (delta < {22'd0, max_step_ff}) ? delta[9:0] : max_step_ff;
            w_ff       <= (gyro_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : gyro_weight_ff;
            idx_ff     <= '0;
            sel_ff     <= 1'b0;
         end
         ST_SQ_Z: sum_ff <= 44'(prod_ff);
         ST_SQ_SUM: begin
            v_ff   <= {sq_in, 16'd0};
            r_ff   <= '0;
            bit_ff <= 48'd1 << 46;
            cnt_ff <= '0;
         end
         ST_SQRT: begin
            if (v_ff >= sq_trial) begin
               v_ff <= v_ff - sq_trial;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_ROLL_WAIT: if (cordic_done) acc_roll_ff <= cordic_angle;
         ST_RATE_RECIP: nsign_ff <= prod_ff[57];
         ST_RATE_INC: begin
            inc_ff[idx_ff] <= nsign_ff ? -$signed(q_mag) : $signed(q_mag);
            idx_ff         <= idx_ff + 1'b1;
         end
         ST_PITCH_WAIT: if (cordic_done) acc_pitch_ff <= cordic_angle;
         ST_BLEND_A: sum_ff <= prod_ff[43:0];
         ST_BLEND_FIN: sel_ff <= 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_roll_deg  = out_roll_ff;
   assign rsp_pitch_deg = out_pitch_ff;
   assign rsp_yaw_deg   = out_yaw_ff;

   a_beat_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_SQ_Y))
      else $error("accepted beat did not start the sequencer");

   a_roll_done_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROLL_WAIT && cordic_done) |=> (state_ff == ST_RATE_MUL))
      else $error("roll angle ready but sequencer did not move on");

   a_done_posts_response: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished sample was not posted");

endmodule

`default_nettype wire
